// File: rtl/core/ble_adv_pkg.sv
package ble_adv_pkg;

   localparam logic       OpStart     = 1'b0;
   localparam logic       OpPayload   = 1'b1;

   localparam logic [23:0] CrcSeed    = 24'h555555;
   localparam logic [23:0] CrcPoly    = 24'h00065B;
   localparam logic [7:0]  WhitenTap  = 8'h11;
   localparam logic [7:0]  WhitenMark = 8'h02;
   localparam logic [7:0]  TxAddBit   = 8'h40;
   localparam logic [7:0]  RandomTop  = 8'hC0;
   localparam logic [7:0]  LengthBase = 8'h06;

   localparam logic [3:0]  StartBytes   = 4'd8;
   localparam logic [3:0]  PayloadBytes = 4'd1;
   localparam logic [1:0]  CrcLastIdx   = 2'd2;

   typedef struct packed {
      logic        op;
      logic [7:0]  pdu_header;
      logic [47:0] mac_address;
      logic [5:0]  payload_count;
      logic [5:0]  channel;
      logic [7:0]  payload_byte;
   } item_type;

   typedef struct packed {
      logic       emit;
      logic       last;
      logic [7:0] data;
   } beat_type;

   typedef struct packed {
      logic [7:0] state;
      logic [7:0] data;
   } whiten_type;

   function automatic logic [7:0] bitrev8(input logic [7:0] a);
      logic [7:0] v;
      for (int i = 0; i < 8; i++) begin
         v[7 - i] = a[i];
      end
      return v;
   endfunction

   // CRC-24, data LSB first
   function automatic logic [23:0] crc_byte(input logic [23:0] crc, input logic [7:0] d);
      logic [23:0] c;
      logic        top;
      c = crc;
      for (int i = 0; i < 8; i++) begin
         top = c[23];
         c = {c[22:0], 1'b0};
         if (top != d[i]) begin
            c = c ^ CrcPoly;
         end
      end
      return c;
   endfunction

   function automatic whiten_type whiten_byte(input logic [7:0] w, input logic [7:0] d);
      whiten_type r;
      logic [7:0] s;
      logic [7:0] x;
      s = w;
      x = d;
      for (int i = 0; i < 8; i++) begin
         if (s[7]) begin
            s = s ^ WhitenTap;
            x[i] = ~x[i];
         end
         s = {s[6:0], 1'b0};
      end
      r.state = s;
      r.data = x;
      return r;
   endfunction

endpackage

// File: rtl/core/ble_adv_framer.sv
module ble_adv_framer #(
   parameter int MAX_PAYLOAD = 21
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  ble_adv_pkg::item_type req_item,
   input  logic                 out_free,
   output ble_adv_pkg::beat_type beat
);
   import ble_adv_pkg::*;

   localparam logic [5:0] MaxCount = 6'(MAX_PAYLOAD);

   logic        hold_valid_ff, hold_valid_in;
   item_type    item_ff, item_in;
   logic [3:0]  step_ff, step_in;
   logic [4:0]  left_ff, left_in;
   logic [23:0] crc_ff, crc_in;
   logic [7:0]  white_ff, white_in;

   logic        is_start, first, is_crc, closing, drop, fire, done, load, emit;
   logic [5:0]  cnt_sat;
   logic [7:0]  hdr, data_raw, crc_sel, raw, white_base;
   logic [3:0]  data_n;
   logic [1:0]  crc_idx;
   logic [23:0] crc_base;
   whiten_type  wr;

   always_comb begin
      is_start = item_ff.op == OpStart;
      first = is_start && (step_ff == 4'd0);
      cnt_sat = (item_ff.payload_count > MaxCount) ? MaxCount : item_ff.payload_count;
      hdr = item_ff.pdu_header;
      if (((item_ff.mac_address[47:40] & RandomTop) == RandomTop) || !item_ff.mac_address[0]) begin
         hdr = hdr | TxAddBit;
      end
      data_n = is_start ? StartBytes : PayloadBytes;
      is_crc = step_ff >= data_n;
      crc_idx = 2'(step_ff - data_n);
      closing = is_start ? (cnt_sat == 6'd0) : ((step_ff == 4'd0) ? (left_ff == 5'd1) : 1'b1);
      drop = !is_start && (step_ff == 4'd0) && (left_ff == 5'd0);
      fire = hold_valid_ff && (drop || out_free);
      done = drop || (is_crc ? (crc_idx == CrcLastIdx)
                             : ((step_ff == data_n - 4'd1) && !closing));
      emit = fire && !drop;

      if (is_start) begin
         case (step_ff)
            4'd0:    data_raw = hdr;
            4'd1:    data_raw = LengthBase + {2'b00, cnt_sat};
            4'd2:    data_raw = item_ff.mac_address[7:0];
            4'd3:    data_raw = item_ff.mac_address[15:8];
            4'd4:    data_raw = item_ff.mac_address[23:16];
            4'd5:    data_raw = item_ff.mac_address[31:24];
            4'd6:    data_raw = item_ff.mac_address[39:32];
            4'd7:    data_raw = item_ff.mac_address[47:40];
            default: data_raw = 8'h00;
         endcase
      end else begin
         data_raw = item_ff.payload_byte;
      end

      case (crc_idx)
         2'd0:    crc_sel = bitrev8(crc_ff[23:16]);
         2'd1:    crc_sel = bitrev8(crc_ff[15:8]);
         default: crc_sel = bitrev8(crc_ff[7:0]);
      endcase

      raw = is_crc ? crc_sel : data_raw;
      crc_base = first ? CrcSeed : crc_ff;
      white_base = first ? (bitrev8({2'b00, item_ff.channel}) | WhitenMark) : white_ff;
      wr = whiten_byte(white_base, raw);

      beat.emit = emit;
      beat.last = is_crc && (crc_idx == CrcLastIdx);
      beat.data = bitrev8(wr.data);

      req_ready = !hold_valid_ff || (fire && done);
      load = req_valid && req_ready;

      hold_valid_in = load ? 1'b1 : ((fire && done) ? 1'b0 : hold_valid_ff);
      item_in = load ? req_item : item_ff;
      step_in = load ? 4'd0 : (fire ? step_ff + 4'd1 : step_ff);

      left_in = left_ff;
      if (emit && (step_ff == 4'd0)) begin
         left_in = is_start ? cnt_sat[4:0] : left_ff - 5'd1;
      end
      crc_in = (emit && !is_crc) ? crc_byte(crc_base, raw) : crc_ff;
      white_in = emit ? wr.state : white_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_valid_ff <= 1'b0;
         step_ff <= 4'd0;
         left_ff <= 5'd0;
         crc_ff <= CrcSeed;
         white_ff <= 8'h00;
      end else begin
         hold_valid_ff <= hold_valid_in;
         step_ff <= step_in;
         left_ff <= left_in;
         crc_ff <= crc_in;
         white_ff <= white_in;
      end
   end

   always_ff @(posedge clock) begin
      item_ff <= item_in;
   end

`ifndef SYNTHESIS
   a_step_range: assert property (@(posedge clock) disable iff (reset)
      hold_valid_ff |-> (step_ff <= 4'd10))
      else $error("framer step out of range");

   a_close_clears: assert property (@(posedge clock) disable iff (reset)
      (beat.emit && beat.last) |=> (left_ff == 5'd0))
      else $error("payload count left after closing beat");

   a_no_idle_emit: assert property (@(posedge clock) disable iff (reset)
      !hold_valid_ff |-> !beat.emit)
      else $error("beat emitted with no item held");

   a_drop_silent: assert property (@(posedge clock) disable iff (reset)
      (hold_valid_ff && drop) |-> (!beat.emit && req_ready))
      else $error("dropped payload item produced a beat");
`endif

endmodule

// File: rtl/core/ble_adv_out_stage.sv
module ble_adv_out_stage (
   input  logic                 clock,
   input  logic                 reset,
   input  ble_adv_pkg::beat_type beat,
   output logic                 out_free,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [7:0]           rsp_tdata,
   output logic                 rsp_tlast
);
   import ble_adv_pkg::*;

   logic       valid_ff, valid_in;
   logic [7:0] data_ff, data_in;
   logic       last_ff, last_in;

   always_comb begin
      out_free = !valid_ff || rsp_tready;
      valid_in = beat.emit ? 1'b1 : (rsp_tready ? 1'b0 : valid_ff);
      data_in = beat.emit ? beat.data : data_ff;
      last_in = beat.emit ? beat.last : last_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
      last_ff <= last_in;
   end

   assign rsp_tvalid = valid_ff;
   assign rsp_tdata = data_ff;
   assign rsp_tlast = last_ff;

endmodule

// File: rtl/core/ble_adv_packet_encoder.sv
// BLE advertising packet framer. A start beat (req_tuser = 0) emits the header
// (TxAdd set for a random-looking address), the length byte and the six address
// bytes; each payload beat (req_tuser = 1) emits one byte. After the last payload
// byte the three CRC-24 bytes follow, the final one flagged by rsp_tlast. All
// bytes are whitened from the channel seed and bit-reversed for an MSB-first radio.
// Payload counts saturate to MAX_PAYLOAD; payload beats with no open packet are
// dropped. Rate: one output byte per cycle from a single held item, barring
// rsp_tready stalls; a dropped beat emits no byte, and a new item is accepted as
// soon as the held one is done.
module ble_adv_packet_encoder #(
   parameter int MAX_PAYLOAD = 21
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // pdu_header[7:0], mac_address[55:8], payload_count[61:56], channel[67:62],
   // payload_byte[75:68], zero[79:76]
   input  logic [79:0] req_tdata,
   // op[0]
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // output_byte[7:0]
   output logic [7:0]  rsp_tdata,
   output logic        rsp_tlast
);
   import ble_adv_pkg::*;

   item_type req_item;
   beat_type beat;
   logic     out_free;

   always_comb begin
      req_item.op = req_tuser;
      req_item.pdu_header = req_tdata[7:0];
      req_item.mac_address = req_tdata[55:8];
      req_item.payload_count = req_tdata[61:56];
      req_item.channel = req_tdata[67:62];
      req_item.payload_byte = req_tdata[75:68];
   end

   ble_adv_framer #(
      .MAX_PAYLOAD(MAX_PAYLOAD)
   ) u_framer (
      .clock(clock),
      .reset(reset),
      .req_valid(req_tvalid),
      .req_ready(req_tready),
      .req_item(req_item),
      .out_free(out_free),
      .beat(beat)
   );

   ble_adv_out_stage u_out (
      .clock(clock),
      .reset(reset),
      .beat(beat),
      .out_free(out_free),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tlast(rsp_tlast)
   );

endmodule

// File: tb/ble_adv_checker.sv
`timescale 1ns / 100ps

module ble_adv_checker #(
   parameter int MAX_PAYLOAD = 21
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [79:0] req_tdata,
   input  logic        req_tuser,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [7:0]  rsp_tdata,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          backlog
);
   import ble_adv_pkg::*;

   typedef struct packed {
      logic [7:0] air;
      logic       last;
   } air_beat_type;

   air_beat_type air_queue[$];
   air_beat_type want;
   item_type     seen_beat;
   logic [23:0]  crc_acc;
   logic [7:0]   lfsr;
   logic [4:0]   bytes_left;
   logic         pkt_open;

   task flag_mismatch(input string what);
      if (fail_count < 100) begin
         $display("tb: mismatch at %0t: %s", $realtime, what);
      end
      fail_count++;
   endtask

   function logic [7:0] mirror8(input logic [7:0] b);
      return {<<{b}};
   endfunction

   function void crc_absorb(input logic [7:0] d);
      logic fb;
      for (int i = 0; i < 8; i++) begin
         fb = crc_acc[23] ^ d[i];
         crc_acc = {crc_acc[22:0], 1'b0};
         if (fb) begin
            crc_acc ^= CrcPoly;
         end
      end
   endfunction

   function logic [7:0] scramble(input logic [7:0] d);
      logic [7:0] x;
      x = d;
      for (int i = 0; i < 8; i++) begin
         if (lfsr[7]) begin
            lfsr ^= WhitenTap;
            x[i] = ~x[i];
         end
         lfsr = {lfsr[6:0], 1'b0};
      end
      return x;
   endfunction

   function void queue_air(input logic [7:0] b, input logic last);
      air_beat_type nb;
      nb.air = mirror8(scramble(b));
      nb.last = last;
      air_queue.push_back(nb);
   endfunction

   function void absorb_and_queue(input logic [7:0] b);
      crc_absorb(b);
      queue_air(b, 1'b0);
   endfunction

   function void close_packet();
      queue_air(mirror8(crc_acc[23:16]), 1'b0);
      queue_air(mirror8(crc_acc[15:8]), 1'b0);
      queue_air(mirror8(crc_acc[7:0]), 1'b1);
      pkt_open = 1'b0;
      bytes_left = '0;
   endfunction

   function void frame_beat(input item_type it);
      logic [7:0] hdr;
      logic [5:0] cnt;
      if (it.op == OpStart) begin
         cnt = (it.payload_count > MAX_PAYLOAD) ? 6'(MAX_PAYLOAD) : it.payload_count;
         hdr = it.pdu_header;
         // random-looking address sets TxAdd
         if ((hdr & TxAddBit) == 8'h00 &&
             ((it.mac_address[47:40] & RandomTop) == RandomTop || !it.mac_address[0])) begin
            hdr |= TxAddBit;
         end
         crc_acc = CrcSeed;
         lfsr = mirror8({2'b00, it.channel}) | WhitenMark;
         absorb_and_queue(hdr);
         absorb_and_queue(LengthBase + 8'(cnt));
         for (int k = 0; k < 6; k++) begin
            absorb_and_queue(it.mac_address[8*k +: 8]);
         end
         bytes_left = cnt[4:0];
         pkt_open = 1'b1;
         if (bytes_left == 0) begin
            close_packet();
         end
      end else if (!pkt_open || bytes_left == 0) begin
         pkt_open = 1'b0;
      end else begin
         absorb_and_queue(it.payload_byte);
         bytes_left--;
         if (bytes_left == 0) begin
            close_packet();
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         crc_acc = CrcSeed;
         lfsr = '0;
         bytes_left = '0;
         pkt_open = 1'b0;
         air_queue.delete();
      end else begin
         if (req_tvalid && req_tready) begin
            seen_beat.op = req_tuser;
            seen_beat.pdu_header = req_tdata[7:0];
            seen_beat.mac_address = req_tdata[55:8];
            seen_beat.payload_count = req_tdata[61:56];
            seen_beat.channel = req_tdata[67:62];
            seen_beat.payload_byte = req_tdata[75:68];
            frame_beat(seen_beat);
         end
         if (rsp_tvalid && rsp_tready) begin
            if (air_queue.size() == 0) begin
               flag_mismatch($sformatf("unexpected beat data %02h last %0b",
                                       rsp_tdata, rsp_tlast));
            end else begin
               want = air_queue.pop_front();
               if (rsp_tdata !== want.air) begin
                  flag_mismatch($sformatf("output_byte %02h, expected %02h",
                                          rsp_tdata, want.air));
               end
               if (rsp_tlast !== want.last) begin
                  flag_mismatch($sformatf("last_byte %0b, expected %0b",
                                          rsp_tlast, want.last));
               end
            end
         end
      end
      backlog <= air_queue.size();
   end

endmodule

// File: tb/tb_top.sv
`timescale 1ns / 100ps

module tb_top;
   import ble_adv_pkg::*;

   localparam int PayloadCap  = 21;
   localparam int RandomItems = 350;
   localparam int CycleLimit  = 200000;
   localparam int DrainCycles = 24;
   localparam int HoldCycles  = 400;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [79:0] req_tdata = '0;
   logic        req_tuser = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [7:0]  rsp_tdata;
   logic        rsp_tlast;

   int fail_count;
   int backlog;
   int sent = 0;
   int framed = 0;
   int cycles = 0;
   bit calm = 1'b0;

   always #1 clock = ~clock;

   ble_adv_packet_encoder #(
      .MAX_PAYLOAD(PayloadCap)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast)
   );

   ble_adv_checker #(
      .MAX_PAYLOAD(PayloadCap)
   ) u_check (
      .clock     (clock),
      .reset     (reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata (rsp_tdata),
      .rsp_tlast (rsp_tlast),
      .fail_count(fail_count),
      .backlog   (backlog)
   );

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CycleLimit) begin
         $display("tb: failure");
         $finish;
      end
   end

   function automatic item_type random_item(input logic op);
      item_type it;
      it.op = op;
      it.pdu_header = 8'($urandom);
      it.mac_address = {16'($urandom), 32'($urandom)};
      it.payload_count = 6'($urandom);
      it.channel = ($urandom_range(3) == 0) ? 6'($urandom) : 6'($urandom_range(39));
      it.payload_byte = 8'($urandom);
      return it;
   endfunction

   function automatic item_type start_beat(input logic [7:0] pdu, input logic [47:0] mac,
                                           input int cnt, input int ch);
      item_type it;
      it = random_item(OpStart);
      it.pdu_header = pdu;
      it.mac_address = mac;
      it.payload_count = 6'(cnt);
      it.channel = 6'(ch);
      return it;
   endfunction

   function automatic item_type data_beat(input logic [7:0] b);
      item_type it;
      it = random_item(OpPayload);
      it.payload_byte = b;
      return it;
   endfunction

   // valid stays high on return; a random gap in the next call or the caller lowers it
   task automatic send_beat(input item_type it);
      while (!calm && $urandom_range(99) < 29) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {4'b0000, it.payload_byte, it.channel, it.payload_count,
                    it.mac_address, it.pdu_header};
      req_tuser <= it.op;
      @(posedge clock);
      while (!req_tready) begin
         @(posedge clock);
      end
      sent++;
   endtask

   task automatic send_packet(input int cnt, input int keep);
      int n;
      send_beat(start_beat(8'($urandom), {16'($urandom), 32'($urandom)}, cnt,
                           ($urandom_range(3) == 0) ? $urandom_range(63)
                                                    : $urandom_range(39)));
      n = (cnt > PayloadCap) ? PayloadCap : cnt;
      if (keep < n) begin
         n = keep;
      end
      for (int k = 0; k < n; k++) begin
         send_beat(data_beat(8'($urandom)));
      end
      framed += n + 1;
   endtask

   // receiver: random stalls, one long hold-off
   initial begin
      int hold;
      bit held;
      hold = 0;
      held = 1'b0;
      @(posedge clock);
      forever begin
         if (!held && sent >= 120) begin
            held = 1'b1;
            hold = HoldCycles;
         end
         if (hold > 0) begin
            hold--;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= calm || ($urandom_range(99) >= 29);
         end
         @(posedge clock);
      end
   end

   initial begin
      int roll;
      int cnt;
      bit paused;
      paused = 1'b0;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      send_beat(data_beat(8'h3C));                            // no packet open
      send_beat(start_beat(8'h00, 48'h0000_0000_0000, 0, 0));
      send_beat(start_beat(8'hFF, 48'hFFFF_FFFF_FFFF, 0, 63));
      send_beat(start_beat(8'h02, 48'hC012_3456_7801, 1, 37));
      send_beat(data_beat(8'hFF));
      send_beat(start_beat(8'h00, 48'h8000_0000_0001, 2, 39));
      send_beat(data_beat(8'h00));
      send_beat(data_beat(8'hA5));
      send_beat(start_beat(8'h46, 48'h3FFF_FFFF_FFFE, 63, 38)); // saturates
      for (int k = 0; k < 3; k++) begin
         send_beat(data_beat(8'($urandom)));
      end
      send_beat(start_beat(8'hBF, 48'h7FAA_AA55_5581, 1, 12)); // abandons open packet
      send_beat(data_beat(8'h5A));
      send_beat(data_beat(8'h77));                            // after close

      framed = 0;
      while (framed < RandomItems) begin
         calm = (framed >= 150 && framed < 230);
         if (!paused && framed >= 260) begin
            paused = 1'b1;
            req_tvalid <= 1'b0;
            do @(posedge clock); while (backlog != 0);
         end
         roll = $urandom_range(99);
         cnt = $urandom_range(9);
         if (cnt < 6) begin
            cnt = $urandom_range(8);
         end else if (cnt < 9) begin
            cnt = $urandom_range(21, 9);
         end else begin
            cnt = $urandom_range(63, 22);
         end
         if (roll < 6) begin
            send_packet(cnt + 2, $urandom_range(cnt + 1, 1));
         end else if (roll < 12) begin
            send_beat(random_item(OpPayload));
         end else begin
            send_packet(cnt, PayloadCap);
         end
      end
      calm = 1'b0;

      req_tvalid <= 1'b0;
      do @(posedge clock); while (backlog != 0);
      repeat (DrainCycles) @(posedge clock);
      if (fail_count == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
